// File: rtl/mipmapped_wavetable_oscillator_macros.svh
// Assertion macros for the wavetable oscillator.
`ifndef MIPMAPPED_WAVETABLE_OSCILLATOR_MACROS_SVH
`define MIPMAPPED_WAVETABLE_OSCILLATOR_MACROS_SVH

`ifndef SYNTHESIS

`define WTO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define WTO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define WTO_ASSERT(label, prop, msg)
`define WTO_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// File: rtl/wto_pkg.sv
// Shared types and constants of the wavetable oscillator.
`default_nettype none

package wto_pkg;

  localparam int NUM_TABLES_DEF       = 2;
  localparam int MIP_LEVELS_DEF       = 8;
  localparam int SAMPLES_PER_WAVE_DEF = 256;
  localparam int WAVES_PER_TABLE_DEF  = 64;
  localparam int SAMPLE_BITS_DEF      = 16;

  localparam int ADDR_W  = 18;
  localparam int DATA_W  = 16;
  localparam int POS_W   = 14;
  localparam int WAVE_W  = 6;
  localparam int FRAC_W  = 16;
  localparam int XF_W    = 8;
  localparam int CFG_IDX_W = 8;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INC   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SEL = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_POS  = 8'd3;

  localparam logic [31:0] PHASE_INC_RST = 32'd39370534;
  localparam logic [31:0] MIN_INC_RST   = 32'd1789570;

  // mip level is raised while half-band samples times increment exceed this
  localparam logic [63:0] LEVEL_LIMIT = 64'h0000_0000_C000_0000;

  typedef struct packed {
    logic              en;
    logic [FRAC_W-1:0] frac;
  } lerp_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/mipmapped_wavetable_oscillator.sv
// Mipmapped wavetable oscillator top level: sequencer, registers and datapath.
`default_nettype none

// A write (tuser 1) or a phase clear (tuser 2) leaves the input side ready and gives no word.
// A sample request (tuser 0) keeps the input side busy through the mip search, one step per
// level raised to reach the selected mip level, four reads of the single wave memory port with
// two interpolations on the shared multiplier, one crossfade on the same unit, and the load of
// the output register. That load waits while the output register still holds an unread word.
// The next item is taken while the finished word still waits on the output side.

module mipmapped_wavetable_oscillator #(
  parameter int NUM_TABLES       = wto_pkg::NUM_TABLES_DEF,
  parameter int MIP_LEVELS       = wto_pkg::MIP_LEVELS_DEF,
  parameter int SAMPLES_PER_WAVE = wto_pkg::SAMPLES_PER_WAVE_DEF,
  parameter int WAVES_PER_TABLE  = wto_pkg::WAVES_PER_TABLE_DEF,
  parameter int SAMPLE_BITS      = wto_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // table_address[17:0], table_data[33:18], zero pad
  input  wire logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // sample_out[15:0]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int MEM_DEPTH = NUM_TABLES * MIP_LEVELS * WAVES_PER_TABLE * SAMPLES_PER_WAVE;
  localparam int AW   = $clog2(MEM_DEPTH);
  localparam int IXW  = $clog2(SAMPLES_PER_WAVE);
  localparam int TBW  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int LVW  = (MIP_LEVELS > 1) ? $clog2(MIP_LEVELS) : 1;
  localparam int DW   = SAMPLE_BITS;
  localparam int PPW  = 32 + IXW;
  localparam int WW   = wto_pkg::WAVE_W;
  localparam logic [wto_pkg::POS_W-1:0] MAX_POS =
    wto_pkg::POS_W'((WAVES_PER_TABLE - 1) * 256);
  localparam logic [2:0] LAST_STEP = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_FETCH,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic [2:0] step_q;
  logic       out_valid_q;
  logic [15:0] out_q;

  logic [31:0] phase_inc_q, min_inc_q, phase_q;
  logic        table_sel_q;
  logic [wto_pkg::POS_W-1:0] wave_pos_q;

  logic [31:0]    e_q;
  logic [IXW-1:0] avail_q;
  logic [LVW-1:0] level_q;
  logic [TBW-1:0] tbl_q;
  logic [WW-1:0]  wlo_q, whi_q;
  logic [wto_pkg::XF_W-1:0]   xf_q;
  logic [IXW-1:0] i0_q, i1_q;
  logic [wto_pkg::FRAC_W-1:0] f_q;
  logic signed [DW-1:0] a_q, lo_q;

  logic        in_accept;
  logic [1:0]  in_action;
  logic [wto_pkg::ADDR_W-1:0] in_addr;
  logic signed [wto_pkg::DATA_W-1:0] in_data;

  logic [PPW-1:0] ph_prod;
  logic [PPW-1:0] lvl_prod;
  logic           lvl_up;
  logic [wto_pkg::POS_W-1:0] pos_sat;
  logic [WW-1:0]  wlo_d;
  logic [IXW-1:0] i0_d;

  logic [AW-1:0]  rd_addr, mem_addr, row_addr;
  logic [WW-1:0]  rd_wave;
  logic           wr_en, rd_en;
  logic signed [DW-1:0] mem_rdata;

  wto_pkg::lerp_ctrl_t lerp_ctrl;
  logic signed [DW-1:0] lerp_a, lerp_b, lerp_res;
  logic out_free;

  assign in_action = s_axis_tuser;
  assign in_addr   = s_axis_tdata[17:0];
  assign in_data   = $signed(s_axis_tdata[33:18]);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;

  // phase times table length: integer part is the index, next 16 bits the fraction
  assign ph_prod = PPW'(phase_q) * PPW'(SAMPLES_PER_WAVE);
  assign i0_d    = ph_prod[PPW-1:32];

  assign pos_sat = (wave_pos_q > MAX_POS) ? MAX_POS : wave_pos_q;
  assign wlo_d   = pos_sat[wto_pkg::POS_W-1:wto_pkg::XF_W];

  assign lvl_prod = PPW'(avail_q) * PPW'(e_q);
  assign lvl_up   = (level_q < LVW'(MIP_LEVELS - 1)) && (lvl_prod > PPW'(wto_pkg::LEVEL_LIMIT));

  assign rd_wave  = (step_q < 3'd2) ? wlo_q : whi_q;
  assign row_addr = (AW'(tbl_q) * AW'(MIP_LEVELS) + AW'(level_q)) * AW'(WAVES_PER_TABLE)
                    + AW'(rd_wave);
  assign rd_addr  = row_addr * AW'(SAMPLES_PER_WAVE) + AW'(step_q[0] ? i1_q : i0_q);

  assign wr_en    = in_accept && (in_action == wto_pkg::ACT_WRITE) &&
                    (64'(in_addr) < 64'(MEM_DEPTH));
  assign rd_en    = (state_q == ST_FETCH) && (step_q < 3'd4);
  assign mem_addr = (state_q == ST_IDLE) ? AW'(in_addr) : rd_addr;

  wto_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (wr_en || rd_en),
    .we_i    (wr_en),
    .addr_i  (mem_addr),
    .wdata_i (DW'(in_data)),
    .rdata_o (mem_rdata)
  );

  assign lerp_ctrl.en   = (state_q == ST_FETCH) &&
                          ((step_q == 3'd2) || (step_q == 3'd4) || (step_q == LAST_STEP));
  assign lerp_ctrl.frac = (step_q == LAST_STEP) ? {xf_q, 8'b0} : f_q;
  assign lerp_a         = (step_q == LAST_STEP) ? lo_q : a_q;
  assign lerp_b         = (step_q == LAST_STEP) ? lerp_res : mem_rdata;

  wto_lerp #(
    .DW (DW)
  ) u_lerp (
    .clk_i  (clk_i),
    .ctrl_i (lerp_ctrl),
    .a_i    (lerp_a),
    .b_i    (lerp_b),
    .res_o  (lerp_res)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q <= wto_pkg::PHASE_INC_RST;
      min_inc_q   <= wto_pkg::MIN_INC_RST;
      table_sel_q <= 1'b0;
      wave_pos_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        wto_pkg::REG_PHASE_INC: phase_inc_q <= cfg_data_i;
        wto_pkg::REG_MIN_INC:   min_inc_q   <= cfg_data_i;
        wto_pkg::REG_TABLE_SEL: table_sel_q <= cfg_data_i[0];
        wto_pkg::REG_WAVE_POS:  wave_pos_q  <= cfg_data_i[wto_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      phase_q     <= '0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            case (in_action)
              wto_pkg::ACT_SAMPLE: begin
                phase_q <= phase_q + phase_inc_q;
                level_q <= '0;
                state_q <= ST_LEVEL;
              end
              wto_pkg::ACT_CLEAR: phase_q <= '0;
              default: ;
            endcase
          end
        end
        ST_LEVEL: begin
          if (lvl_up) begin
            level_q <= level_q + 1'b1;
          end else begin
            step_q  <= '0;
            state_q <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          step_q <= step_q + 1'b1;
          if (step_q == LAST_STEP) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept && (in_action == wto_pkg::ACT_SAMPLE)) begin
      e_q     <= (phase_inc_q > min_inc_q) ? phase_inc_q : min_inc_q;
      avail_q <= IXW'(SAMPLES_PER_WAVE / 2);
      tbl_q   <= (32'(table_sel_q) < 32'(NUM_TABLES)) ? TBW'(table_sel_q) : TBW'(NUM_TABLES - 1);
      wlo_q   <= wlo_d;
      whi_q   <= (wlo_d == WW'(WAVES_PER_TABLE - 1)) ? wlo_d : wlo_d + 1'b1;
      xf_q    <= pos_sat[wto_pkg::XF_W-1:0];
      i0_q    <= i0_d;
      i1_q    <= (i0_d == IXW'(SAMPLES_PER_WAVE - 1)) ? '0 : i0_d + 1'b1;
      f_q     <= ph_prod[31:16];
    end
    if (state_q == ST_LEVEL && lvl_up) begin
      avail_q <= avail_q >> 1;
    end
    if (state_q == ST_FETCH && (step_q == 3'd1 || step_q == 3'd3)) begin
      a_q <= mem_rdata;
    end
    if (state_q == ST_FETCH && step_q == 3'd3) begin
      lo_q <= lerp_res;
    end
    if (state_q == ST_FINISH && out_free) begin
      out_q <= 16'(lerp_res);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`include "mipmapped_wavetable_oscillator_macros.svh"

  `WTO_ASSERT(a_busy_not_ready, (state_q != ST_IDLE) |-> !s_axis_tready, "ready while busy")
  `WTO_ASSERT(a_phase_step, (in_accept && in_action == wto_pkg::ACT_SAMPLE) |=> (phase_q == $past(phase_q + phase_inc_q)), "phase not advanced")
  `WTO_ASSERT(a_level_range, level_q <= LVW'(MIP_LEVELS - 1), "mip level out of range")
  `WTO_ASSERT(a_word_from_finish, $rose(out_valid_q) |-> $past(state_q == ST_FINISH), "word loaded outside finish")
  `WTO_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (state_q == ST_IDLE && !out_valid_q), "not idle in reset")

endmodule

`default_nettype wire

// File: rtl/wto_mem.sv
// Single-port wave memory with registered read data.
`default_nettype none

module wto_mem #(
  parameter int DEPTH = 2,
  parameter int AW    = 1,
  parameter int DW    = 16
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/wto_lerp.sv
// Shared interpolation unit: a + floor((b - a) * frac / 2^16), registered.
`default_nettype none

module wto_lerp #(
  parameter int DW = 16
) (
  input  wire logic                clk_i,
  input  wire wto_pkg::lerp_ctrl_t ctrl_i,
  input  wire logic signed [DW-1:0] a_i,
  input  wire logic signed [DW-1:0] b_i,
  output logic signed      [DW-1:0] res_o
);

  localparam int PW = DW + wto_pkg::FRAC_W + 2;

  logic signed [DW:0]   diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] sum;
  logic signed [DW-1:0] res_q;

  assign diff = (DW+1)'(b_i) - (DW+1)'(a_i);
  assign prod = PW'(diff) * PW'($signed({1'b0, ctrl_i.frac}));
  assign sum  = PW'(a_i) + (prod >>> wto_pkg::FRAC_W);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      res_q <= DW'(sum);
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire
